FILE: rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms, clocked on clk and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define PKQL_ASSERT_IMPL(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication.
`define PKQL_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: rtl/pkql_pkg.sv
// ----------------------------------------------------------------------------
// pkql_pkg
// Shared constants, status codes, controller states, and command and status structs.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package pkql_pkg;

	localparam int NUM_QUEUES_DEF  = 8;
	localparam int QUEUE_DEPTH_DEF = 16;

	localparam logic [2:0] STAT_INSERTED    = 3'd0;
	localparam logic [2:0] STAT_DELETED     = 3'd1;
	localparam logic [2:0] STAT_NO_PRIORITY = 3'd2;
	localparam logic [2:0] STAT_EMPTY       = 3'd3;
	localparam logic [2:0] STAT_FULL        = 3'd4;

	localparam logic OP_INSERT = 1'b0;
	localparam logic OP_DELETE = 1'b1;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_TAG_RD,
		ST_TAG_CMP,
		ST_QS_RD,
		ST_EXEC,
		ST_JOB_RD,
		ST_DONE
	} ctrl_state_t;

	typedef struct packed {
		logic in_load;
		logic tag_re;
		logic scan_inc;
		logic found_set;
		logic qs_re;
		logic exec;
		logic job_capture;
		logic out_load;
	} dp_cmd_t;

	typedef struct packed {
		logic used_zero;
		logic tag_match;
		logic scan_last;
		logic pop_go;
	} dp_stat_t;

endpackage

FILE: rtl/priority_keyed_queue_list.sv
// Flow: a transfer compares the claimed tags in turn, reads the queue state on a match,
// runs the update step, reads the job byte for a successful delete, and loads the
// output register. Throughput: one item at a time, set by the serial tag scan; the
// next transfer is taken only after the result is loaded.
// Reset clears the claimed-slot count and the control state; no clearing pass is run.
// ----------------------------------------------------------------------------
// priority_keyed_queue_list
// A set of FIFO queues, each tagged with a priority value, with insert/delete.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module priority_keyed_queue_list #(
	parameter int NUM_QUEUES  = pkql_pkg::NUM_QUEUES_DEF,
	parameter int QUEUE_DEPTH = pkql_pkg::QUEUE_DEPTH_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic       operation,
	input  logic [7:0] job_code,
	input  logic [7:0] priority_key,
	output logic       out_valid,
	input  logic       out_ready,
	output logic [2:0] status,
	output logic [7:0] removed_job
);

	import pkql_pkg::*;

	// Slots are claimed in order from slot zero and are never released, so the
	// claimed slots always form a prefix. The datapath keeps only a count of
	// them: the tag and queue-state memories need no reset, since an entry is
	// read only after the claim that wrote it. Job bytes are read only where an
	// earlier insert wrote them.
	//
	// Each transfer walks the claimed tags one by one. A match reads the
	// queue's head and count; the update step then either appends the job,
	// claims the next free slot, pops the head entry, or reports a status.
	// The result sits in an output register, and the next input transfer can
	// be taken while that result still waits for the consumer.

	dp_cmd_t  cmd;
	dp_stat_t stat;

	pkql_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.stat      (stat),
		.cmd       (cmd)
	);

	pkql_datapath #(
		.NUM_QUEUES  (NUM_QUEUES),
		.QUEUE_DEPTH (QUEUE_DEPTH)
	) u_datapath (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.stat         (stat),
		.operation    (operation),
		.job_code     (job_code),
		.priority_key (priority_key),
		.status       (status),
		.removed_job  (removed_job)
	);

endmodule

FILE: rtl/pkql_ram.sv
// ----------------------------------------------------------------------------
// pkql_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module pkql_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16,
	parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic              clk,
	input  logic              we,
	input  logic [ADDR_W-1:0] waddr,
	input  logic [WIDTH-1:0]  wdata,
	input  logic              re,
	input  logic [ADDR_W-1:0] raddr,
	output logic [WIDTH-1:0]  rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

FILE: rtl/pkql_datapath.sv
// ----------------------------------------------------------------------------
// pkql_datapath
// Tag, queue-state and job memories, scan registers and result registers.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module pkql_datapath #(
	parameter int NUM_QUEUES  = pkql_pkg::NUM_QUEUES_DEF,
	parameter int QUEUE_DEPTH = pkql_pkg::QUEUE_DEPTH_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  pkql_pkg::dp_cmd_t  cmd,
	output pkql_pkg::dp_stat_t stat,
	input  logic               operation,
	input  logic [7:0]         job_code,
	input  logic [7:0]         priority_key,
	output logic [2:0]         status,
	output logic [7:0]         removed_job
);

	import pkql_pkg::*;

	localparam int SLOT_W = (NUM_QUEUES > 1) ? $clog2(NUM_QUEUES) : 1;
	localparam int USED_W = $clog2(NUM_QUEUES + 1);
	localparam int HEAD_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int CNT_W  = $clog2(QUEUE_DEPTH + 1);
	localparam int SUM_W  = CNT_W + 1;
	localparam int JOBS   = NUM_QUEUES * QUEUE_DEPTH;
	localparam int ADDR_W = (JOBS > 1) ? $clog2(JOBS) : 1;
	localparam int QS_W   = HEAD_W + CNT_W;

	logic              op_q;
	logic [7:0]        job_q;
	logic [7:0]        key_q;
	logic [SLOT_W-1:0] scan_idx_q;
	logic [SLOT_W-1:0] slot_q;
	logic              found_q;
	logic [USED_W-1:0] used_q;
	logic [2:0]        res_status_q;
	logic [7:0]        res_job_q;
	logic [2:0]        status_q;
	logic [7:0]        removed_q;

	logic [7:0]        tag_rdata;
	logic [QS_W-1:0]   qs_rdata;
	logic [7:0]        job_rdata;

	logic [HEAD_W-1:0] head_eff;
	logic [CNT_W-1:0]  cnt_eff;
	logic [SLOT_W-1:0] slot_eff;
	logic [HEAD_W-1:0] head_new;
	logic [CNT_W-1:0]  cnt_new;
	logic [SUM_W-1:0]  pos_sum;
	logic [HEAD_W-1:0] pos;
	logic [ADDR_W-1:0] job_addr;
	logic [2:0]        exec_status;
	logic              tag_we;
	logic              qs_we;
	logic              job_we;
	logic              job_re;
	logic              claim;
	logic              pop;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scan_idx_q <= '0;
			slot_q     <= '0;
			found_q    <= 1'b0;
			used_q     <= '0;
		end else begin
			if (cmd.in_load) begin
				scan_idx_q <= '0;
				found_q    <= 1'b0;
			end else if (cmd.scan_inc) begin
				scan_idx_q <= scan_idx_q + SLOT_W'(1);
			end
			if (cmd.found_set) begin
				found_q <= 1'b1;
				slot_q  <= scan_idx_q;
			end
			if (claim) begin
				used_q <= used_q + USED_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.in_load) begin
			op_q  <= operation;
			job_q <= job_code;
			key_q <= priority_key;
		end
		if (cmd.exec) begin
			res_status_q <= exec_status;
			res_job_q    <= '0;
		end else if (cmd.job_capture) begin
			res_job_q <= job_rdata;
		end
		if (cmd.out_load) begin
			status_q  <= res_status_q;
			removed_q <= res_job_q;
		end
	end

	// A slot that is not yet claimed starts with an empty queue at head zero.
	assign head_eff = found_q ? qs_rdata[QS_W-1:CNT_W] : '0;
	assign cnt_eff  = found_q ? qs_rdata[CNT_W-1:0] : '0;
	assign slot_eff = found_q ? slot_q : used_q[SLOT_W-1:0];

	always_comb begin
		pos_sum = SUM_W'(head_eff) + SUM_W'(cnt_eff);
		if (pos_sum >= SUM_W'(QUEUE_DEPTH)) begin
			pos_sum = pos_sum - SUM_W'(QUEUE_DEPTH);
		end
		pos = pos_sum[HEAD_W-1:0];
	end

	assign job_addr = ADDR_W'(slot_eff) * ADDR_W'(QUEUE_DEPTH)
		+ ADDR_W'((op_q == OP_DELETE) ? head_eff : pos);

	always_comb begin
		tag_we      = 1'b0;
		qs_we       = 1'b0;
		job_we      = 1'b0;
		job_re      = 1'b0;
		claim       = 1'b0;
		pop         = 1'b0;
		head_new    = head_eff;
		cnt_new     = cnt_eff;
		exec_status = STAT_FULL;
		if (op_q == OP_INSERT) begin
			if (found_q ? (cnt_eff != CNT_W'(QUEUE_DEPTH))
				: (used_q != USED_W'(NUM_QUEUES))) begin
				exec_status = STAT_INSERTED;
				qs_we       = cmd.exec;
				job_we      = cmd.exec;
				tag_we      = cmd.exec && !found_q;
				claim       = cmd.exec && !found_q;
				cnt_new     = cnt_eff + CNT_W'(1);
			end
		end else begin
			if (!found_q) begin
				exec_status = STAT_NO_PRIORITY;
			end else if (cnt_eff == '0) begin
				exec_status = STAT_EMPTY;
			end else begin
				exec_status = STAT_DELETED;
				pop         = 1'b1;
				job_re      = cmd.exec;
				qs_we       = cmd.exec;
				cnt_new     = cnt_eff - CNT_W'(1);
				if (head_eff == HEAD_W'(QUEUE_DEPTH - 1)) begin
					head_new = '0;
				end else begin
					head_new = head_eff + HEAD_W'(1);
				end
			end
		end
	end

	pkql_ram #(.WIDTH(8), .DEPTH(NUM_QUEUES), .ADDR_W(SLOT_W)) u_tag_ram (
		.clk   (clk),
		.we    (tag_we),
		.waddr (slot_eff),
		.wdata (key_q),
		.re    (cmd.tag_re),
		.raddr (scan_idx_q),
		.rdata (tag_rdata)
	);

	pkql_ram #(.WIDTH(QS_W), .DEPTH(NUM_QUEUES), .ADDR_W(SLOT_W)) u_qs_ram (
		.clk   (clk),
		.we    (qs_we),
		.waddr (slot_eff),
		.wdata ({head_new, cnt_new}),
		.re    (cmd.qs_re),
		.raddr (slot_q),
		.rdata (qs_rdata)
	);

	pkql_ram #(.WIDTH(8), .DEPTH(JOBS), .ADDR_W(ADDR_W)) u_job_ram (
		.clk   (clk),
		.we    (job_we),
		.waddr (job_addr),
		.wdata (job_q),
		.re    (job_re),
		.raddr (job_addr),
		.rdata (job_rdata)
	);

	assign stat.used_zero = (used_q == '0);
	assign stat.tag_match = (tag_rdata == key_q);
	assign stat.scan_last = ((USED_W'(scan_idx_q) + USED_W'(1)) == used_q);
	assign stat.pop_go    = pop;

	assign status      = status_q;
	assign removed_job = removed_q;

endmodule

FILE: rtl/pkql_ctrl.sv
// ----------------------------------------------------------------------------
// pkql_ctrl
// Sequencer for tag scan, queue update, job read and result hand-off.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module pkql_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	output logic               out_valid,
	input  logic               out_ready,
	input  pkql_pkg::dp_stat_t stat,
	output pkql_pkg::dp_cmd_t  cmd
);

	import pkql_pkg::*;

	ctrl_state_t state_q;
	ctrl_state_t state_d;
	logic        out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		in_ready = 1'b0;
		case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.in_load = 1'b1;
					state_d     = stat.used_zero ? ST_EXEC : ST_TAG_RD;
				end
			end
			ST_TAG_RD: begin
				cmd.tag_re = 1'b1;
				state_d    = ST_TAG_CMP;
			end
			ST_TAG_CMP: begin
				if (stat.tag_match) begin
					cmd.found_set = 1'b1;
					state_d       = ST_QS_RD;
				end else if (stat.scan_last) begin
					state_d = ST_EXEC;
				end else begin
					cmd.scan_inc = 1'b1;
					state_d      = ST_TAG_RD;
				end
			end
			ST_QS_RD: begin
				cmd.qs_re = 1'b1;
				state_d   = ST_EXEC;
			end
			ST_EXEC: begin
				cmd.exec = 1'b1;
				state_d  = stat.pop_go ? ST_JOB_RD : ST_DONE;
			end
			ST_JOB_RD: begin
				cmd.job_capture = 1'b1;
				state_d         = ST_DONE;
			end
			ST_DONE: begin
				if (!out_valid_q || out_ready) begin
					cmd.out_load = 1'b1;
					state_d      = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	assign out_valid = out_valid_q;

endmodule

FILE: rtl/pkql_checker.sv
// ----------------------------------------------------------------------------
// pkql_checker
// Port-level assertions for the priority-keyed queue list, attached by bind.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module pkql_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       in_valid,
	input logic       in_ready,
	input logic       out_valid,
	input logic       out_ready,
	input logic [2:0] status,
	input logic [7:0] removed_job
);

	import pkql_pkg::*;

	logic out_stall;

	assign out_stall = out_valid && !out_ready;

	// A stalled result keeps its status.
	`PKQL_ASSERT_NEXT(a_out_hold, out_stall, out_valid && $stable(status), "stalled result changed")

	// Only the five defined status codes are ever reported.
	`PKQL_ASSERT_IMPL(a_status_code, out_valid, status <= STAT_FULL, "undefined status code")

	// Only a successful delete carries a job byte.
	`PKQL_ASSERT_IMPL(a_removed_zero, out_valid && status != STAT_DELETED, removed_job == 8'd0, "stray job")

	// After an input transfer the block is busy on that item.
	`PKQL_ASSERT_NEXT(a_busy_after_accept, in_valid && in_ready, !in_ready, "ready after a transfer")

endmodule

bind priority_keyed_queue_list pkql_checker u_pkql_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.in_valid    (in_valid),
	.in_ready    (in_ready),
	.out_valid   (out_valid),
	.out_ready   (out_ready),
	.status      (status),
	.removed_job (removed_job)
);
